>>> rtl/swk_pkg.sv
// Shared types, constants and the arctangent table of the swerve wheel kinematics block.
`timescale 1ns / 1ps

package swk_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    // widths: k = yaw * lever, wheel component, CORDIC x/y and angle accumulator
    localparam int KW = 18;
    localparam int CW = 19;
    localparam int XW = 29;
    localparam int ZW = 21;
    localparam int ATAN_IW = 5;

    localparam logic [15:0] GAIN_INV_Q16 = 16'd39797;
    localparam logic signed [ZW-1:0] HALF_TURN_Z = 21'sd368796;
    localparam logic signed [ZW-1:0] ANGLE_LIMIT = 21'sd23047;
    localparam logic signed [15:0] CROSS_ANGLE = 16'sd5760;

    typedef enum logic [1:0] {
        CFG_LEVER = 2'd0,
        CFG_INV_RADIUS = 2'd1,
        CFG_THRESHOLD = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        MODE_RUN = 2'd0,
        MODE_STOP = 2'd1,
        MODE_LOCK = 2'd2
    } t_hold_mode;

    // controller -> datapath
    typedef struct packed {
        logic       accept;
        logic       prep;
        logic       load;
        logic       iter;
        logic       mul;
        logic       fin;
        logic [1:0] wheel;
    } t_swk_cmd;

    // datapath -> controller
    typedef struct packed {
        logic iter_last;
        logic out_free;
    } t_swk_sts;

    // atan(2^-i) in 1/2048 scaled degrees
    function automatic logic signed [ZW-1:0] swk_atan(input logic [ATAN_IW-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0: v = 21'sd92199;
            5'd1: v = 21'sd54428;
            5'd2: v = 21'sd28758;
            5'd3: v = 21'sd14598;
            5'd4: v = 21'sd7327;
            5'd5: v = 21'sd3667;
            5'd6: v = 21'sd1834;
            5'd7: v = 21'sd917;
            5'd8: v = 21'sd459;
            5'd9: v = 21'sd229;
            5'd10: v = 21'sd115;
            5'd11: v = 21'sd57;
            5'd12: v = 21'sd29;
            5'd13: v = 21'sd14;
            5'd14: v = 21'sd7;
            5'd15: v = 21'sd4;
            5'd16: v = 21'sd2;
            5'd17: v = 21'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/swerve_wheel_kinematics.sv
// Top level of the four-wheel swerve inverse kinematics block.
//
//  channel  direction  beat contents
//  s_axis   in         tdata: vx_speed, vy_speed, yaw_rate, hold_mode
//  m_axis   out        tdata: wheel_speed, steer_angle; tuser: wheel_index; tlast: last_wheel
//  cfg      in         i_cfg_index selects wheel_lever / inv_wheel_radius / still_threshold
//
// One input beat gives four output beats, wheel 0 first. Per beat: an accept state, a state
// for the lever and gain products, then per wheel a load, the CORDIC iterations on the
// shared rotator, a multiply and an output state.
// A stalled output keeps the next wheel in the multiply register; the next input is taken
// while the fourth result still waits.
// Reset is synchronous, no clearing pass.
`timescale 1ns / 1ps

module swerve_wheel_kinematics
    import swk_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // vx_speed[15:0], vy_speed[31:16], yaw_rate[47:32],
                                        // hold_mode[49:48], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // wheel_speed[15:0], steer_angle[31:16]
    output logic [1:0]  m_axis_tuser,   // wheel_index[1:0]
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_swk_cmd w_cmd;
    t_swk_sts w_sts;

    assign o_cfg_ready = 1'b1;

    swk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    swk_dpath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

    // the last flag marks exactly wheel 3
    a_last_wheel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 2'd3)))
        else $error("tlast does not match wheel index");

    // while idle only the fourth result may still be pending
    a_idle_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tready && m_axis_tvalid) |-> m_axis_tlast)
        else $error("input taken with an unfinished item");

    // steering angle stays inside the clamp range
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[31:16]) <= 16'sd23047
                           && $signed(m_axis_tdata[31:16]) >= -16'sd23047))
        else $error("steer angle out of range");

    // a new output beat follows a wheel that was just handed over in order
    a_wheel_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
            ##1 (m_axis_tvalid && !$stable(m_axis_tuser))
            |-> (m_axis_tuser == $past(m_axis_tuser) + 2'd1))
        else $error("wheel results out of order");

endmodule

>>> rtl/swk_ctrl.sv
// Sequencer for the four wheel passes of the swerve kinematics block.
`timescale 1ns / 1ps

module swk_ctrl
    import swk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_swk_sts i_sts,
    output t_swk_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_LOAD = 6'b000100,
        S_ITER = 6'b001000,
        S_MUL  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_wheel, n_wheel;

    always_comb begin
        n_state = r_state;
        n_wheel = r_wheel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_wheel = '0;
                n_state = S_LOAD;
            end
            S_LOAD: n_state = S_ITER;
            S_ITER: begin
                if (i_sts.iter_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_FIN;
            S_FIN: begin
                if (i_sts.out_free) begin
                    n_wheel = r_wheel + 2'd1;
                    n_state = (r_wheel == 2'd3) ? S_IDLE : S_LOAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wheel <= '0;
        end else begin
            r_state <= n_state;
            r_wheel <= n_wheel;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.prep   = (r_state == S_PREP);
    assign o_cmd.load   = (r_state == S_LOAD);
    assign o_cmd.iter   = (r_state == S_ITER);
    assign o_cmd.mul    = (r_state == S_MUL);
    assign o_cmd.fin    = (r_state == S_FIN) && i_sts.out_free;
    assign o_cmd.wheel  = r_wheel;

endmodule

>>> rtl/swk_dpath.sv
// Datapath: config registers, wheel vectors, CORDIC vectoring, speed scaling, angle hold.
`timescale 1ns / 1ps

module swk_dpath
    import swk_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [55:0] i_in_data,
    input  t_swk_cmd    i_cmd,
    output t_swk_sts    o_sts,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [31:0] o_out_data,
    output logic [1:0]  o_out_user,
    output logic        o_out_last
);

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int PW = (XW - 1) + 32;

    // configuration
    logic [12:0] r_lever;
    logic [15:0] r_inv_radius;
    logic [11:0] r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lever      <= 13'd869;
            r_inv_radius <= 16'd4267;
            r_threshold  <= 12'd41;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LEVER:      r_lever      <= i_cfg_data[12:0];
                CFG_INV_RADIUS: r_inv_radius <= i_cfg_data;
                CFG_THRESHOLD:  r_threshold  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // captured command
    logic signed [15:0] r_vx, r_vy, r_w;
    logic [1:0]         r_mode;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_vx   <= i_in_data[15:0];
            r_vy   <= i_in_data[31:16];
            r_w    <= i_in_data[47:32];
            r_mode <= i_in_data[49:48];
        end
    end

    // per-item terms: lever product, stillness, combined speed gain
    logic signed [29:0]   w_kprod;
    logic signed [KW-1:0] n_k;
    logic [16:0]          w_abs_vx, w_abs_vy;
    logic                 n_still;
    logic [31:0]          n_gain;
    logic signed [KW-1:0] r_k;
    logic                 r_still;
    logic [31:0]          r_gain;

    always_comb begin
        w_kprod  = r_w * $signed({1'b0, r_lever});
        n_k      = KW'((w_kprod + 30'sd2048) >>> 12);
        w_abs_vx = r_vx[15] ? 17'(-18'(r_vx)) : 17'(r_vx);
        w_abs_vy = r_vy[15] ? 17'(-18'(r_vy)) : 17'(r_vy);
        n_still  = (w_abs_vx <= {5'b0, r_threshold}) && (w_abs_vy <= {5'b0, r_threshold})
                   && (r_w == '0);
        n_gain   = GAIN_INV_Q16 * r_inv_radius;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_k     <= n_k;
            r_still <= n_still;
            r_gain  <= n_gain;
        end
    end

    // CORDIC vectoring unit, one micro-rotation a cycle
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [IW-1:0]        r_cnt;
    logic signed [CW-1:0] w_cx, w_cy;
    logic signed [XW-1:0] w_xs, w_ys, w_dx, w_dy;
    logic signed [ZW-1:0] w_atan;

    function automatic logic r_cmd_plus_x(input logic [1:0] wheel);
        return wheel[1];
    endfunction

    function automatic logic r_cmd_plus_y(input logic [1:0] wheel);
        return (wheel == 2'd0) || (wheel == 2'd3);
    endfunction

    always_comb begin
        w_cx   = r_cmd_plus_x(i_cmd.wheel) ? CW'(r_vx) + CW'(r_k) : CW'(r_vx) - CW'(r_k);
        w_cy   = r_cmd_plus_y(i_cmd.wheel) ? CW'(r_vy) + CW'(r_k) : CW'(r_vy) - CW'(r_k);
        w_xs   = {{(XW-CW-8){w_cx[CW-1]}}, w_cx, 8'b0};
        w_ys   = {{(XW-CW-8){w_cy[CW-1]}}, w_cy, 8'b0};
        w_dx   = r_y >>> r_cnt;
        w_dy   = r_x >>> r_cnt;
        w_atan = swk_atan(ATAN_IW'(r_cnt));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cnt <= '0;
            if (w_cx[CW-1]) begin
                // left half plane: flip by 180 degrees first
                r_x <= -w_xs;
                r_y <= -w_ys;
                r_z <= w_cy[CW-1] ? -HALF_TURN_Z : HALF_TURN_Z;
            end else begin
                r_x <= w_xs;
                r_y <= w_ys;
                r_z <= '0;
            end
        end else if (i_cmd.iter) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_y > 0) begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end else if (r_y < 0) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end
        end
    end

    assign o_sts.iter_last = (r_cnt == IW'(CORDIC_STEPS - 1));

    // magnitude times gain, angle rounding and clamp
    logic [XW-2:0]        w_mag;
    logic signed [ZW-1:0] w_za;
    logic signed [15:0]   n_ang;
    logic [PW-1:0]        r_prod;
    logic signed [15:0]   r_ang;

    always_comb begin
        w_mag = r_x[XW-1] ? '0 : r_x[XW-2:0];
        w_za  = (r_z + ZW'(8)) >>> 4;
        if (w_za > ANGLE_LIMIT) begin
            n_ang = 16'(ANGLE_LIMIT);
        end else if (w_za < -ANGLE_LIMIT) begin
            n_ang = 16'(-ANGLE_LIMIT);
        end else begin
            n_ang = 16'(w_za);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PW'(w_mag) * PW'(r_gain);
            r_ang  <= n_ang;
        end
    end

    // speed rounding, saturation and the held angle
    logic [PW:0]        w_rsum;
    logic [PW-38:0]     w_speed_full;
    logic [15:0]        w_speed;
    logic signed [15:0] r_held [4];
    logic signed [15:0] n_held;

    always_comb begin
        w_rsum       = {1'b0, r_prod} + ((PW+1)'(1) << 37);
        w_speed_full = w_rsum[PW:38];
        w_speed      = (|w_speed_full[PW-38:16]) ? 16'hFFFF : w_speed_full[15:0];
        n_held       = r_held[i_cmd.wheel];
        if (!r_still) begin
            n_held = r_ang;
        end else if (r_mode == MODE_LOCK) begin
            n_held = i_cmd.wheel[0] ? CROSS_ANGLE : -CROSS_ANGLE;
        end else if (r_mode == MODE_STOP) begin
            n_held = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_held[i] <= '0;
            end
        end else if (i_cmd.fin) begin
            r_held[i_cmd.wheel] <= n_held;
        end
    end

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic [1:0]  r_out_user;
    logic        r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out_data <= {n_held, w_speed};
            r_out_user <= i_cmd.wheel;
            r_out_last <= (i_cmd.wheel == 2'd3);
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;
    assign o_out_user     = r_out_user;
    assign o_out_last     = r_out_last;

endmodule
